@@ rtl/core/double_ended_queue_ring_unit_defines.svh @@
// Assertion macros used by the queue back end (dqr_back).
`ifndef DOUBLE_ENDED_QUEUE_RING_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_RING_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons holds too.
`define DQR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define DQR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define DQR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define DQR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/core/dqr_pkg.sv @@
package dqr_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int VAL_W = 32;

   // command queue between front and back
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

   localparam logic [2:0] FUNC_INS_FRONT = 3'd0;
   localparam logic [2:0] FUNC_INS_REAR  = 3'd1;
   localparam logic [2:0] FUNC_REM_FRONT = 3'd2;
   localparam logic [2:0] FUNC_REM_REAR  = 3'd3;
   localparam logic [2:0] FUNC_LIST      = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]              func;
      logic signed [VAL_W-1:0] value_in;
   } dqr_req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value_out;
      logic [1:0]              status;
      logic                    last_of_run;
   } dqr_rsp_type;

   // decoded command handed from front to back
   typedef struct packed {
      logic                    insert;
      logic                    list_all;
      logic                    at_rear;
      logic signed [VAL_W-1:0] value;
   } dqr_cmd_type;

endpackage

@@ rtl/core/dqr_front.sv @@
module dqr_front
   import dqr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dqr_req_type req_data,
   output logic        cmd_valid,
   input  logic        cmd_stall,
   output dqr_cmd_type cmd_data
);

   dqr_cmd_type        q_mem [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CW-1:0] cnt_ff, cnt_in;

   dqr_cmd_type dec;
   logic        dec_ok;
   logic        push;
   logic        pop;

   always_comb begin
      dec          = '0;
      dec.value    = req_data.value_in;
      dec_ok       = 1'b1;
      unique case (req_data.func)
         FUNC_INS_FRONT: begin
            dec.insert = 1'b1;
         end
         FUNC_INS_REAR: begin
            dec.insert  = 1'b1;
            dec.at_rear = 1'b1;
         end
         FUNC_REM_FRONT: begin
         end
         FUNC_REM_REAR: begin
            dec.at_rear = 1'b1;
         end
         FUNC_LIST: begin
            dec.list_all = 1'b1;
         end
         default: begin
            dec_ok = 1'b0;  // unused codes are taken and dropped
         end
      endcase
   end

   assign req_stall = (cnt_ff == CMDQ_CW'(CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = q_mem[rd_ptr_ff];

   assign push = req_valid && !req_stall && dec_ok;
   assign pop  = cmd_valid && !cmd_stall;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + CMDQ_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + CMDQ_AW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CMDQ_CW'(push) - CMDQ_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= dec;
      end
   end

endmodule

@@ rtl/core/dqr_back.sv @@
`include "double_ended_queue_ring_unit_defines.svh"

module dqr_back
   import dqr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_stall,
   input  dqr_cmd_type cmd_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dqr_rsp_type rsp_data
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_LIST = 1'b1;

   logic [VAL_W-1:0] mem [DEPTH];

   logic             state_ff, state_in;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] list_idx_ff, list_idx_in;

   logic             pend_ff, pend_in;
   logic             pend_mem_ff, pend_mem_in;
   logic [1:0]       pend_status_ff, pend_status_in;
   logic             pend_last_ff, pend_last_in;
   logic [VAL_W-1:0] rdata_ff;

   logic             out_valid_ff, out_valid_in;
   dqr_rsp_type      out_ff;

   logic             can_issue;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] new_front;
   logic             is_full;
   logic             is_empty;
   logic             list_last;

   function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offset);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(base) + (CNT_W+1)'(offset);
      if (s >= (CNT_W+1)'(DEPTH)) begin
         s = s - (CNT_W+1)'(DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   // an issued read goes through rdata_ff and pend_ff, so the output slot must be free for it
   assign can_issue = !pend_ff && (!out_valid_ff || !rsp_stall);
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign new_front = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
   assign list_last = ((list_idx_ff + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in       = state_ff;
      front_in       = front_ff;
      count_in       = count_ff;
      list_idx_in    = list_idx_ff;
      pend_in        = 1'b0;
      pend_mem_in    = 1'b0;
      pend_status_in = ST_OK;
      pend_last_in   = 1'b1;
      wr_en          = 1'b0;
      wr_addr        = front_ff;
      rd_en          = 1'b0;
      rd_addr        = front_ff;
      cmd_stall      = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            cmd_stall = !can_issue;
            if (cmd_valid && can_issue) begin
               if (cmd_data.list_all) begin
                  list_idx_in = '0;
                  if (is_empty) begin
                     pend_in        = 1'b1;
                     pend_status_in = ST_EMPTY;
                  end else begin
                     state_in = S_LIST;
                  end
               end else if (cmd_data.insert) begin
                  pend_in = 1'b1;
                  if (is_full) begin
                     pend_status_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     if (cmd_data.at_rear) begin
                        wr_addr = ring_pos(front_ff, count_ff);
                     end else begin
                        wr_addr  = new_front;
                        front_in = new_front;
                     end
                  end
               end else begin
                  pend_in = 1'b1;
                  if (is_empty) begin
                     pend_status_in = ST_EMPTY;
                  end else begin
                     rd_en       = 1'b1;
                     pend_mem_in = 1'b1;
                     count_in    = count_ff - CNT_W'(1);
                     if (cmd_data.at_rear) begin
                        rd_addr = ring_pos(front_ff, count_ff - CNT_W'(1));
                     end else begin
                        front_in = ring_pos(front_ff, CNT_W'(1));
                     end
                  end
               end
            end
         end
         S_LIST: begin
            if (can_issue) begin
               pend_in      = 1'b1;
               pend_mem_in  = 1'b1;
               pend_last_in = list_last;
               rd_en        = 1'b1;
               rd_addr      = ring_pos(front_ff, list_idx_ff);
               list_idx_in  = list_idx_ff + CNT_W'(1);
               if (list_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_valid_in = pend_ff || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         list_idx_ff  <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         list_idx_ff  <= list_idx_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_mem_ff    <= pend_mem_in;
      pend_status_ff <= pend_status_in;
      pend_last_ff   <= pend_last_in;
      if (pend_ff) begin
         out_ff.value_out   <= pend_mem_ff ? rdata_ff : '0;
         out_ff.status      <= pend_status_ff;
         out_ff.last_of_run <= pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= cmd_data.value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `DQR_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "count beyond depth")
   `DQR_ASSERT_IMP(a_slot_free, clock, reset, pend_ff, !out_valid_ff, "output slot busy on load")
   `DQR_ASSERT_IMP(a_list_nonempty, clock, reset, state_ff == S_LIST, list_idx_ff < count_ff, "list index past count")
   `DQR_ASSERT_NXT(a_list_hold, clock, reset, state_ff == S_LIST, $stable(count_ff) && $stable(front_ff), "pointers moved while listing")

endmodule

@@ rtl/core/double_ended_queue_ring_unit.sv @@
// Double-ended queue of signed 32-bit values held in a 16-entry ring.
// Input channel req_*: one item per request, func selects insert front,
// insert rear, remove front, remove rear or list; value_in is the element.
// Unused func codes are taken and produce nothing.
// Result channel rsp_*: value_out, status (ok, empty, full) and last_of_run,
// which marks the final result of a request. A list gives one result per
// element, front to rear; an empty queue gives one result with status empty.
// A decoder and a two-entry command queue sit in front of the executing
// back end, so requests keep being taken while the back end is busy.
// A request waits in the command queue; once the back end issues it, its result
// passes through the pending registers (pend_ff, rdata_ff) and then the output
// register. The back end issues one ring read or write at a time (registered
// ring read, then output register) and takes no new command or list element
// while a result is still pending, so inserts, removals and list reads never overlap.
// Reset (synchronous) empties the queue; ring contents are not cleared.
// While rsp_stall is high the result holds and the back end waits; once the
// command queue fills, req_stall rises.
module double_ended_queue_ring_unit
   import dqr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dqr_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dqr_rsp_type rsp_data
);

   logic        cmd_valid;
   logic        cmd_stall;
   dqr_cmd_type cmd_data;

   dqr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_stall (cmd_stall),
      .cmd_data  (cmd_data)
   );

   dqr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_stall (cmd_stall),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
